// ===== design/running_rms_level_detector_assert.svh =====
// ----------------------------------------------------------------------------
// Running RMS level detector: assertion macros
// Shared concurrent assertion forms, same cycle and next cycle.
// ----------------------------------------------------------------------------
`ifndef RUNNING_RMS_LEVEL_DETECTOR_ASSERT_SVH
`define RUNNING_RMS_LEVEL_DETECTOR_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define RRLD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rrld assertion failed");

// antecedent implies consequent in the next cycle
`define RRLD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rrld assertion failed");

`endif

// ===== design/rrld_pkg.sv =====
// ----------------------------------------------------------------------------
// rrld_pkg
// Widths, types, register codes and limits of the running RMS level detector.
// ----------------------------------------------------------------------------
package rrld_pkg;

   localparam int SAMPLE_BITS = 16;                    // Q1.(S-1) samples
   localparam int MAG_BITS    = SAMPLE_BITS;           // |x| up to 2^(S-1)
   localparam int MS_BITS     = 2 * SAMPLE_BITS - 1;   // Q2.(2S-2) mean square
   localparam int WF_BITS     = 13;
   localparam int NC_BITS     = 2;
   localparam int DIV_BITS    = WF_BITS + NC_BITS;     // divisor D
   localparam int NUM_BITS    = MS_BITS + DIV_BITS;    // ms*(D-1) + x*x
   localparam int MULT_STEPS  = (MAG_BITS > DIV_BITS) ? MAG_BITS : DIV_BITS;
   localparam int MULT_CNT_BITS = $clog2(MULT_STEPS);
   localparam int DIV_CNT_BITS  = $clog2(NUM_BITS);
   localparam int ROOT_BITS   = SAMPLE_BITS;
   localparam int RAD_BITS    = 2 * ROOT_BITS;
   localparam int ROOT_CNT_BITS = $clog2(ROOT_BITS);

   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = WF_BITS;

   typedef logic [MAG_BITS-1:0]  mag_type;
   typedef logic [MS_BITS-1:0]   ms_type;
   typedef logic [DIV_BITS-1:0]  div_type;
   typedef logic [NUM_BITS-1:0]  num_type;
   typedef logic [ROOT_BITS-1:0] root_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_WINDOW_FRAMES = 1'b0,
      CSR_NUM_CHANNELS  = 1'b1
   } csr_index_type;

   localparam logic [WF_BITS-1:0] WF_RESET = WF_BITS'(480);
   localparam logic [NC_BITS-1:0] NC_RESET = NC_BITS'(2);

   localparam ms_type   MS_MAX   = ms_type'(1) << (2 * SAMPLE_BITS - 2);
   localparam root_type ROOT_MAX = root_type'(1) << (SAMPLE_BITS - 1);

endpackage

// ===== design/running_rms_level_detector.sv =====
// Sequencing: each request runs the 16-step serial multiply-accumulate and the 46-step
//   serial divider; block ends add two 16-step square roots, after which the result
//   shows on rsp_valid once the result register is free. A new request is taken only
//   once the block is back in idle (later if the previous result is still stalled).
// Reset (synchronous, active high): mean squares and saved RMS values clear to zero,
//   window_frames returns to 480 and num_channels to 2; no clearing pass.
// ----------------------------------------------------------------------------
// running_rms_level_detector
// Two-channel leaky mean-square tracker with RMS readout at block ends.
// ----------------------------------------------------------------------------
`include "running_rms_level_detector_assert.svh"

module running_rms_level_detector
   import rrld_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // configuration
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   // request channel
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [SAMPLE_BITS-1:0]    req_sample,
   input  logic                      req_channel,
   input  logic                      req_block_end,
   // result channel
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output root_type                  rsp_rms_left,
   output root_type                  rsp_rms_right,
   output root_type                  rsp_prev_rms_left,
   output root_type                  rsp_prev_rms_right
);

   // Sequence per request:
   //   MAC    : acc = ms[ch]*(D-1) + |x|^2, one multiplier bit per cycle
   //   DIV    : ms[ch] = acc / D, one quotient bit per cycle
   //   ROOT_L : sqrt(ms[0])   (block end only)
   //   ROOT_R : sqrt(ms[1])
   //   EMIT   : load the result register once it is free
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_DIV,
      ST_ROOT_L,
      ST_ROOT_R,
      ST_EMIT
   } state_type;

   state_type            state_ff, state_in;
   logic [WF_BITS-1:0]   wf_ff, wf_in;
   logic [NC_BITS-1:0]   nc_ff, nc_in;
   ms_type               ms_ff [2];
   ms_type               ms_in [2];
   root_type             prev_ff [2];
   root_type             prev_in [2];
   logic                 ch_ff, ch_in;
   logic                 blk_ff, blk_in;
   root_type             cur_l_ff, cur_l_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   root_type             rsp_l_ff, rsp_l_in;
   root_type             rsp_r_ff, rsp_r_in;
   root_type             rsp_pl_ff, rsp_pl_in;
   root_type             rsp_pr_ff, rsp_pr_in;

   logic                 accept;
   mag_type              mag;
   div_type              d_raw, d, dm1;
   logic                 mac_done, div_done, root_done;
   num_type              mac_acc;
   ms_type               div_quot;
   root_type             root_val;
   logic                 root_start;
   ms_type               ms_fwd_l;
   ms_type               root_radicand;

   // one request at a time; the result register decouples the output side
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // two's-complement magnitude; the most negative code maps to itself
   assign mag = req_sample[SAMPLE_BITS-1] ? (mag_type'(~req_sample) + mag_type'(1))
                                          : mag_type'(req_sample);

   // divisor D = frames * channels, zero treated as one
   assign d_raw = DIV_BITS'(wf_ff) * DIV_BITS'(nc_ff);
   assign d     = (d_raw == '0) ? div_type'(1) : d_raw;
   assign dm1   = d - div_type'(1);

   // left mean square with the fresh quotient forwarded on the DIV exit cycle
   assign ms_fwd_l      = (ch_ff == 1'b0) ? div_quot : ms_ff[0];
   assign root_radicand = (state_ff == ST_DIV) ? ms_fwd_l : ms_ff[1];
   assign root_start    = ((state_ff == ST_DIV) && div_done && blk_ff)
                       || ((state_ff == ST_ROOT_L) && root_done);

   rrld_mac u_mac (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .mag   (mag),
      .ms    (ms_ff[req_channel]),
      .dm1   (dm1),
      .done  (mac_done),
      .acc   (mac_acc)
   );

   rrld_div u_div (
      .clock (clock),
      .reset (reset),
      .start ((state_ff == ST_MAC) && mac_done),
      .num   (mac_acc),
      .den   (d),
      .done  (div_done),
      .quot  (div_quot)
   );

   rrld_root u_root (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (root_radicand),
      .done     (root_done),
      .root     (root_val)
   );

   always_comb begin
      state_in     = state_ff;
      wf_in        = wf_ff;
      nc_in        = nc_ff;
      ms_in        = ms_ff;
      prev_in      = prev_ff;
      ch_in        = ch_ff;
      blk_in       = blk_ff;
      cur_l_in     = cur_l_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_l_in     = rsp_l_ff;
      rsp_r_in     = rsp_r_ff;
      rsp_pl_in    = rsp_pl_ff;
      rsp_pr_in    = rsp_pr_ff;

      // config writes must arrive only while idle; the block itself does not enforce this
      if (csr_we) begin
         unique case (csr_index)
            CSR_WINDOW_FRAMES: wf_in = csr_wdata[WF_BITS-1:0];
            CSR_NUM_CHANNELS:  nc_in = csr_wdata[NC_BITS-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ch_in    = req_channel;
               blk_in   = req_block_end;
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            if (mac_done) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               ms_in[ch_ff] = div_quot;
               state_in     = blk_ff ? ST_ROOT_L : ST_IDLE;
            end
         end
         ST_ROOT_L: begin
            if (root_done) begin
               cur_l_in = root_val;
               state_in = ST_ROOT_R;
            end
         end
         ST_ROOT_R: begin
            if (root_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // root unit still holds the right-channel value
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_l_in     = cur_l_ff;
               rsp_r_in     = root_val;
               rsp_pl_in    = prev_ff[0];
               rsp_pr_in    = prev_ff[1];
               prev_in[0]   = cur_l_ff;
               prev_in[1]   = root_val;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wf_ff        <= WF_RESET;
         nc_ff        <= NC_RESET;
         ms_ff[0]     <= '0;
         ms_ff[1]     <= '0;
         prev_ff[0]   <= '0;
         prev_ff[1]   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wf_ff        <= wf_in;
         nc_ff        <= nc_in;
         ms_ff        <= ms_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ch_ff     <= ch_in;
      blk_ff    <= blk_in;
      cur_l_ff  <= cur_l_in;
      rsp_l_ff  <= rsp_l_in;
      rsp_r_ff  <= rsp_r_in;
      rsp_pl_ff <= rsp_pl_in;
      rsp_pr_ff <= rsp_pr_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_rms_left       = rsp_l_ff;
   assign rsp_rms_right      = rsp_r_ff;
   assign rsp_prev_rms_left  = rsp_pl_ff;
   assign rsp_prev_rms_right = rsp_pr_ff;

   // leaky update never leaves the Q2.30 range
   `RRLD_ASSERT_IMPL(a_ms_range, clock, reset, (state_ff == ST_DIV) && div_done, div_quot <= MS_MAX)
   // root of an in-range mean square fits Q1.15
   `RRLD_ASSERT_IMPL(a_root_range, clock, reset, root_done, root_val <= ROOT_MAX)
   // a new result only ever comes out of the emit step
   `RRLD_ASSERT_IMPL(a_rsp_source, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_EMIT)
   // an accepted request always starts the multiply-accumulate
   `RRLD_ASSERT_NEXT(a_accept_mac, clock, reset, accept, state_ff == ST_MAC)

endmodule

// ===== design/rrld_mac.sv =====
// ----------------------------------------------------------------------------
// rrld_mac
// Bit-serial multiply-accumulate: acc = ms*(D-1) + mag*mag, MSB first.
// ----------------------------------------------------------------------------
module rrld_mac
   import rrld_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  mag_type mag,
   input  ms_type  ms,
   input  div_type dm1,
   output logic    done,
   output num_type acc
);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [MULT_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [MULT_STEPS-1:0]    a_sr_ff, a_sr_in;   // multiplier bits of mag
   logic [MULT_STEPS-1:0]    b_sr_ff, b_sr_in;   // multiplier bits of D-1
   mag_type                  mag_ff, mag_in;
   ms_type                   ms_ff, ms_in;
   num_type                  acc_ff, acc_in;
   num_type                  a_term, b_term;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_sr_in = a_sr_ff;
      b_sr_in = b_sr_ff;
      mag_in  = mag_ff;
      ms_in   = ms_ff;
      acc_in  = acc_ff;
      a_term  = a_sr_ff[MULT_STEPS-1] ? num_type'(mag_ff) : '0;
      b_term  = b_sr_ff[MULT_STEPS-1] ? num_type'(ms_ff) : '0;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         a_sr_in = MULT_STEPS'(mag);
         b_sr_in = MULT_STEPS'(dm1);
         mag_in  = mag;
         ms_in   = ms;
         acc_in  = '0;
      end else if (busy_ff) begin
         acc_in  = (acc_ff << 1) + a_term + b_term;
         a_sr_in = a_sr_ff << 1;
         b_sr_in = b_sr_ff << 1;
         cnt_in  = cnt_ff + MULT_CNT_BITS'(1);
         if (cnt_ff == MULT_CNT_BITS'(MULT_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_sr_ff <= a_sr_in;
      b_sr_ff <= b_sr_in;
      mag_ff  <= mag_in;
      ms_ff   <= ms_in;
      acc_ff  <= acc_in;
   end

   assign done = done_ff;
   assign acc  = acc_ff;

endmodule

// ===== design/rrld_div.sv =====
// ----------------------------------------------------------------------------
// rrld_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rrld_div
   import rrld_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  num_type num,
   input  div_type den,
   output logic    done,
   output ms_type  quot
);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   num_type                 num_sr_ff, num_sr_in;  // dividend out, quotient in
   div_type                 rem_ff, rem_in;
   div_type                 den_ff, den_in;
   logic [DIV_BITS:0]       trial;
   logic                    ge;

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      num_sr_in = num_sr_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      trial     = {rem_ff, num_sr_ff[NUM_BITS-1]};
      ge        = trial >= {1'b0, den_ff};
      if (start) begin
         busy_in   = 1'b1;
         cnt_in    = '0;
         num_sr_in = num;
         rem_in    = '0;
         den_in    = den;
      end else if (busy_ff) begin
         rem_in    = ge ? DIV_BITS'(trial - {1'b0, den_ff}) : trial[DIV_BITS-1:0];
         num_sr_in = {num_sr_ff[NUM_BITS-2:0], ge};
         cnt_in    = cnt_ff + DIV_CNT_BITS'(1);
         if (cnt_ff == DIV_CNT_BITS'(NUM_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_sr_ff <= num_sr_in;
      rem_ff    <= rem_in;
      den_ff    <= den_in;
   end

   // quotient never exceeds the mean-square range
   assign done = done_ff;
   assign quot = num_sr_ff[MS_BITS-1:0];

endmodule

// ===== design/rrld_root.sv =====
// ----------------------------------------------------------------------------
// rrld_root
// Floor square root, two radicand bits per cycle, one root bit per cycle.
// ----------------------------------------------------------------------------
module rrld_root
   import rrld_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  ms_type   radicand,
   output logic     done,
   output root_type root
);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [ROOT_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [RAD_BITS-1:0]      rad_sr_ff, rad_sr_in;
   logic [ROOT_BITS+1:0]     rem_ff, rem_in;
   root_type                 root_ff, root_in;
   logic [ROOT_BITS+1:0]     pend;
   logic [ROOT_BITS+1:0]     trial;
   logic                     ge;

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      rad_sr_in = rad_sr_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      pend      = {rem_ff[ROOT_BITS-1:0], rad_sr_ff[RAD_BITS-1 -: 2]};
      trial     = {root_ff, 2'b01};
      ge        = pend >= trial;
      if (start) begin
         busy_in   = 1'b1;
         cnt_in    = '0;
         rad_sr_in = RAD_BITS'(radicand);
         rem_in    = '0;
         root_in   = '0;
      end else if (busy_ff) begin
         rem_in    = ge ? (pend - trial) : pend;
         root_in   = {root_ff[ROOT_BITS-2:0], ge};
         rad_sr_in = rad_sr_ff << 2;
         cnt_in    = cnt_ff + ROOT_CNT_BITS'(1);
         if (cnt_ff == ROOT_CNT_BITS'(ROOT_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rad_sr_ff <= rad_sr_in;
      rem_ff    <= rem_in;
      root_ff   <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ===== test/running_rms_level_detector_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// running_rms_level_detector_test
// Drives tagged audio samples into the level detector and checks every
// block-end report against a local model of the leaky per-channel mean
// square and its floor square root. A short table of directed requests
// comes first, then random phases under several window settings.
// ----------------------------------------------------------------------------
module running_rms_level_detector_test;
   import rrld_pkg::*;

   localparam int SETTLE_CYCLES  = 150;   // lets a trailing request finish inside the block
   localparam int WATCHDOG_LIMIT = 3000;  // cycles with no request or report moving
   localparam int NUM_PHASES     = 8;
   localparam int PHASE_ITEMS    = 230;

   // one report of the block, field order as on the result ports
   typedef struct packed {
      root_type rms_left;
      root_type rms_right;
      root_type prev_left;
      root_type prev_right;
   } level_report_type;

   // directed row: optional window setting, then one request
   typedef struct packed {
      bit                   set_cfg;
      logic [WF_BITS-1:0]   frames;
      logic [NC_BITS-1:0]   chans;
      logic [SAMPLE_BITS-1:0] sample;
      logic                 channel;
      logic                 block_end;
      bit                   typed;      // want holds the report, else the model decides
      level_report_type     want;
   } probe_row_type;

   localparam int NUM_PROBES = 21;

   // Typed rows after the first run with a divisor of one, where the mean square is
   // just the last square, so the RMS is the sample magnitude.
   localparam probe_row_type PROBES [NUM_PROBES] = '{
      // reset defaults, silence: everything reads zero
      '{1'b0,   13'd0, 2'd0, 16'h0000, 1'b0, 1'b1, 1'b1, '{16'd0, 16'd0, 16'd0, 16'd0}},
      // one frame, one channel: D = 1
      '{1'b1,   13'd1, 2'd1, 16'h7FFF, 1'b0, 1'b1, 1'b1,
        '{16'd32767, 16'd0, 16'd0, 16'd0}},
      // right channel still tracked with only one channel active; full-scale negative
      '{1'b0,   13'd0, 2'd0, 16'h8000, 1'b1, 1'b1, 1'b1,
        '{16'd32767, 16'd32768, 16'd32767, 16'd0}},
      // no block end, no report
      '{1'b0,   13'd0, 2'd0, 16'h0001, 1'b0, 1'b0, 1'b0, '0},
      '{1'b0,   13'd0, 2'd0, 16'hFFFF, 1'b1, 1'b1, 1'b1,
        '{16'd1, 16'd1, 16'd32767, 16'd32768}},
      // zero frames: divisor forced to one
      '{1'b1,   13'd0, 2'd2, 16'h5555, 1'b0, 1'b1, 1'b1,
        '{16'd21845, 16'd1, 16'd1, 16'd1}},
      // zero channels: divisor forced to one
      '{1'b1,   13'd5, 2'd0, 16'hAAAA, 1'b1, 1'b1, 1'b1,
        '{16'd21845, 16'd21846, 16'd21845, 16'd1}},
      // three channels taken literally
      '{1'b1,   13'd1, 2'd3, 16'h4000, 1'b0, 1'b0, 1'b0, '0},
      '{1'b0,   13'd0, 2'd0, 16'hC000, 1'b1, 1'b0, 1'b0, '0},
      '{1'b0,   13'd0, 2'd0, 16'h7FFF, 1'b0, 1'b1, 1'b0, '0},
      '{1'b0,   13'd0, 2'd0, 16'h8000, 1'b1, 1'b1, 1'b0, '0},
      // widest window fields
      '{1'b1, 13'd8191, 2'd3, 16'h8000, 1'b0, 1'b0, 1'b0, '0},
      '{1'b0,   13'd0, 2'd0, 16'h7FFF, 1'b1, 1'b1, 1'b0, '0},
      '{1'b1, 13'd4096, 2'd2, 16'h8000, 1'b1, 1'b1, 1'b0, '0},
      '{1'b1,   13'd2, 2'd1, 16'h8000, 1'b0, 1'b0, 1'b0, '0},
      '{1'b0,   13'd0, 2'd0, 16'h8000, 1'b0, 1'b0, 1'b0, '0},
      '{1'b0,   13'd0, 2'd0, 16'h0000, 1'b1, 1'b1, 1'b0, '0},
      '{1'b0,   13'd0, 2'd0, 16'h1234, 1'b1, 1'b0, 1'b0, '0},
      '{1'b0,   13'd0, 2'd0, 16'hEDCC, 1'b1, 1'b1, 1'b0, '0},
      // back to the reset window
      '{1'b1, 13'd480, 2'd2, 16'h7FFF, 1'b0, 1'b1, 1'b0, '0},
      '{1'b0,   13'd0, 2'd0, 16'h8001, 1'b1, 1'b1, 1'b0, '0}
   };

   // ---------------------------------------------------------------- DUT I/O
   logic                      clock         = 1'b0;
   logic                      reset         = 1'b1;
   logic                      csr_we        = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index     = CSR_WINDOW_FRAMES;
   logic [CSR_DATA_BITS-1:0]  csr_wdata     = '0;
   logic                      req_valid     = 1'b0;
   logic                      req_stall;
   logic [SAMPLE_BITS-1:0]    req_sample    = '0;
   logic                      req_channel   = 1'b0;
   logic                      req_block_end = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall     = 1'b0;
   root_type                  rsp_rms_left;
   root_type                  rsp_rms_right;
   root_type                  rsp_prev_rms_left;
   root_type                  rsp_prev_rms_right;

   running_rms_level_detector u_top (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sample         (req_sample),
      .req_channel        (req_channel),
      .req_block_end      (req_block_end),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_rms_left       (rsp_rms_left),
      .rsp_rms_right      (rsp_rms_right),
      .rsp_prev_rms_left  (rsp_prev_rms_left),
      .rsp_prev_rms_right (rsp_prev_rms_right)
   );

   always #10 clock = ~clock;

   // ------------------------------------------------------------ level model
   logic [WF_BITS-1:0]  cfg_frames = WF_RESET;
   logic [NC_BITS-1:0]  cfg_chans  = NC_RESET;
   logic [63:0]         level_ms [2] = '{64'd0, 64'd0};
   root_type            saved_rms [2] = '{'0, '0};

   level_report_type    pending_levels [$];
   int                  fault_count = 0;
   bit                  idle_on = 1'b1;   // random gaps and stalls allowed
   int                  stall_left = 0;
   int                  quiet_cycles = 0;

   // floor square root, one bit of the root per pass from the top down
   function automatic root_type floor_root(input logic [63:0] v);
      logic [63:0] root;
      logic [63:0] trial;
      root = '0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= v) root = trial;
      end
      return root_type'(root);
   endfunction

   // Apply one sample to its channel's mean square; on block end, form the
   // report and roll the current RMS into the saved pair.
   function automatic level_report_type advance_levels(input logic [SAMPLE_BITS-1:0] smp,
                                                       input logic ch, input logic be);
      logic signed [SAMPLE_BITS:0] wide;
      logic [63:0]                 mag;
      logic [63:0]                 divisor;
      level_report_type            rep;
      wide = {smp[SAMPLE_BITS-1], smp};
      mag = (wide < 0) ? 64'(-wide) : 64'(wide);   // -32768 gives 32768
      divisor = 64'(cfg_frames) * 64'(cfg_chans);
      if (divisor == 0) divisor = 64'd1;
      level_ms[ch] = (level_ms[ch] * (divisor - 64'd1) + mag * mag) / divisor;
      rep = '0;
      if (be) begin
         rep.rms_left   = floor_root(level_ms[0]);
         rep.rms_right  = floor_root(level_ms[1]);
         rep.prev_left  = saved_rms[0];
         rep.prev_right = saved_rms[1];
         saved_rms[0]   = rep.rms_left;
         saved_rms[1]   = rep.rms_right;
      end
      return rep;
   endfunction

   // ------------------------------------------------------- request driving
   // Leaves req_valid high on return so back-to-back requests need no toggle.
   task automatic deliver(input logic [SAMPLE_BITS-1:0] smp, input logic ch, input logic be,
                          input bit typed, input level_report_type want);
      level_report_type got;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample    <= smp;
      req_channel   <= ch;
      req_block_end <= be;
      do @(posedge clock); while (req_stall);
      got = advance_levels(smp, ch, be);
      if (be) pending_levels.insert(pending_levels.size(), typed ? want : got);
   endtask

   // Stop sending and wait for all reports; with settle, also let a
   // trailing non-block-end request finish inside the block.
   task automatic await_results(input bit settle);
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_levels.size() != 0);
      if (settle) repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write both window registers on consecutive edges; block must be idle
   task automatic program_window(input logic [WF_BITS-1:0] frames,
                                 input logic [NC_BITS-1:0] chans);
      csr_we    <= 1'b1;
      csr_index <= CSR_WINDOW_FRAMES;
      csr_wdata <= CSR_DATA_BITS'(frames);
      @(posedge clock);
      csr_index <= CSR_NUM_CHANNELS;
      csr_wdata <= CSR_DATA_BITS'(chans);
      @(posedge clock);
      csr_we     <= 1'b0;
      cfg_frames = frames;
      cfg_chans  = chans;
   endtask

   // ------------------------------------------------------- report receiver
   // random bursts of stalls while idling is on
   always @(posedge clock) begin
      if (reset || !idle_on) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 18);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // compare each accepted report with the oldest expected one
   always @(posedge clock) begin
      level_report_type exp_rep;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_levels.size() == 0) begin
            $error("report with none expected");
            fault_count++;
         end else begin
            exp_rep = pending_levels.pop_front();
            if (rsp_rms_left !== exp_rep.rms_left) begin
               $error("rms_left: expected %0d, actual %0d", exp_rep.rms_left, rsp_rms_left);
               fault_count++;
            end
            if (rsp_rms_right !== exp_rep.rms_right) begin
               $error("rms_right: expected %0d, actual %0d", exp_rep.rms_right, rsp_rms_right);
               fault_count++;
            end
            if (rsp_prev_rms_left !== exp_rep.prev_left) begin
               $error("prev_rms_left: expected %0d, actual %0d",
                      exp_rep.prev_left, rsp_prev_rms_left);
               fault_count++;
            end
            if (rsp_prev_rms_right !== exp_rep.prev_right) begin
               $error("prev_rms_right: expected %0d, actual %0d",
                      exp_rep.prev_right, rsp_prev_rms_right);
               fault_count++;
            end
         end
      end
   end

   // watchdog: nothing moving on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("running_rms_level_detector_test NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------- stimulus
   initial begin
      probe_row_type        row;
      logic [WF_BITS-1:0]   frames;
      logic [NC_BITS-1:0]   chans;
      logic [SAMPLE_BITS-1:0] smp;
      logic                 ch;
      logic                 be;
      int                   hold_at;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (int i = 0; i < NUM_PROBES; i++) begin
         row = PROBES[i];
         if (row.set_cfg) begin
            await_results(1'b1);
            program_window(row.frames, row.chans);
         end
         deliver(row.sample, row.channel, row.block_end, row.typed, row.want);
      end

      // random phases, each under its own window setting
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: begin frames = 13'd3;    chans = 2'd2; end
            1: begin frames = 13'd1;    chans = 2'd1; end
            2: begin frames = 13'd0;    chans = 2'd3; end   // forced D = 1
            3: begin frames = 13'd8191; chans = 2'd3; end
            4: begin frames = 13'd6;    chans = 2'd0; end   // forced D = 1
            5: begin frames = 13'd4096; chans = 2'd1; end
            6: begin
               frames = WF_BITS'($urandom_range(1, 64));
               chans  = NC_BITS'($urandom_range(0, 3));
            end
            default: begin frames = 13'd2; chans = 2'd2; end
         endcase
         await_results(1'b1);
         // phase 2 runs flat out; the last phase has no idling at all
         idle_on = (p != 2) && (p != NUM_PHASES - 1);
         program_window(frames, chans);
         hold_at = $urandom_range(10, PHASE_ITEMS - 10);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // sender holds off until every report is back
            if (n == hold_at) await_results(1'b0);
            case ($urandom_range(0, 9))
               0: begin
                  case ($urandom_range(0, 4))
                     0:       smp = 16'h7FFF;
                     1:       smp = 16'h8000;
                     2:       smp = 16'h0000;
                     3:       smp = 16'h0001;
                     default: smp = 16'hFFFF;
                  endcase
               end
               1, 2:    smp = SAMPLE_BITS'(int'($urandom_range(0, 511)) - 256);
               default: smp = SAMPLE_BITS'($urandom);
            endcase
            ch = 1'($urandom_range(0, 1));
            be = ($urandom_range(0, 3) == 0);
            deliver(smp, ch, be, 1'b0, '0);
         end
      end

      await_results(1'b1);
      if (fault_count == 0) begin
         $display("running_rms_level_detector_test OK");
      end else begin
         $display("running_rms_level_detector_test NOT OK");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+design
design/rrld_pkg.sv
design/rrld_mac.sv
design/rrld_div.sv
design/rrld_root.sv
design/running_rms_level_detector.sv
test/running_rms_level_detector_test.sv
